FILE: sv/rfbdef_pkg.sv
// Shared types, codes and lengths for the RFB client message deframer.
`default_nettype none

package rfbdef_pkg;

    // Session phase, one-hot encoded
    typedef enum logic [3:0] {
        PH_VERSION = 4'b0001,
        PH_INIT    = 4'b0010,
        PH_READY   = 4'b0100,
        PH_CLOSED  = 4'b1000
    } phase_t;

    // Event kinds reported on the output channel
    localparam logic [2:0] KIND_SEND_SECURITY = 3'd0;
    localparam logic [2:0] KIND_SEND_INIT     = 3'd1;
    localparam logic [2:0] KIND_IGNORED       = 3'd2;
    localparam logic [2:0] KIND_UPDATE_REQ    = 3'd3;
    localparam logic [2:0] KIND_KEY           = 3'd4;
    localparam logic [2:0] KIND_POINTER       = 3'd5;
    localparam logic [2:0] KIND_ERROR_CLOSE   = 3'd6;

    // Client message type bytes
    localparam logic [7:0] MSG_SET_PIXEL_FORMAT = 8'd0;
    localparam logic [7:0] MSG_SET_ENCODINGS    = 8'd2;
    localparam logic [7:0] MSG_UPDATE_REQ       = 8'd3;
    localparam logic [7:0] MSG_KEY_EVENT        = 8'd4;
    localparam logic [7:0] MSG_POINTER_EVENT    = 8'd5;
    localparam logic [7:0] MSG_CUT_TEXT         = 8'd6;

    // Stored message type (low three bits of the type byte)
    localparam logic [2:0] TYPE_SET_ENCODINGS = 3'd2;
    localparam logic [2:0] TYPE_UPDATE_REQ    = 3'd3;
    localparam logic [2:0] TYPE_KEY_EVENT     = 3'd4;
    localparam logic [2:0] TYPE_POINTER_EVENT = 3'd5;
    localparam logic [2:0] TYPE_CUT_TEXT      = 3'd6;

    localparam int IDX_W = 33;

    // Byte counts
    localparam logic [IDX_W-1:0] VERSION_LAST      = 33'd11;
    localparam logic [IDX_W-1:0] LEN_PIXEL_FORMAT  = 33'd20;
    localparam logic [IDX_W-1:0] LEN_ENC_HEADER    = 33'd4;
    localparam logic [IDX_W-1:0] LEN_UPDATE_REQ    = 33'd10;
    localparam logic [IDX_W-1:0] LEN_KEY_EVENT     = 33'd8;
    localparam logic [IDX_W-1:0] LEN_POINTER_EVENT = 33'd6;
    localparam logic [IDX_W-1:0] LEN_CUT_HEADER    = 33'd8;

    // Byte positions inside a message
    localparam logic [IDX_W-1:0] POS_TYPE      = 33'd0;
    localparam logic [IDX_W-1:0] POS_FLAG      = 33'd1;
    localparam logic [IDX_W-1:0] POS_HALF_LAST = 33'd3;
    localparam logic [IDX_W-1:0] POS_WORD_LAST = 33'd7;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic        key_pressed;
        logic [31:0] keysym;
        logic [15:0] pointer_x;
        logic [15:0] pointer_y;
        logic [7:0]  button_mask;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/rfb_client_message_deframer_unit.sv
// Top level of the RFB 3.3 client-to-server message deframer.
// Path of a byte to its result: the input register, then the output register.
// Throughput: one byte per cycle; in_stall rises only while both result slots are full.
// Reset: rst_n clears the session to version wait and empties all stages.
`default_nettype none

module rfb_client_message_deframer_unit
    import rfbdef_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   rx_byte,
    input  wire logic         restart,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [2:0]        event_kind,
    output logic              key_pressed,
    output logic [31:0]       keysym,
    output logic [15:0]       pointer_x,
    output logic [15:0]       pointer_y,
    output logic [7:0]        button_mask
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_restart_reg;
    logic       in_accept;
    logic       buf_full;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    out_data;

    assign in_stall      = s1_valid_reg && buf_full;
    assign in_accept     = in_valid && !in_stall;
    assign advance       = s1_valid_reg && !buf_full;
    assign s1_valid_next = in_accept || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // hold the input item until the core takes it
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg    <= rx_byte;
            s1_restart_reg <= restart;
        end
    end

    rfbdef_frame_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (advance),
        .item_byte    (s1_byte_reg),
        .item_restart (s1_restart_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    rfbdef_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign event_kind  = out_data.event_kind;
    assign key_pressed = out_data.key_pressed;
    assign keysym      = out_data.keysym;
    assign pointer_x   = out_data.pointer_x;
    assign pointer_y   = out_data.pointer_y;
    assign button_mask = out_data.button_mask;

endmodule

`default_nettype wire

FILE: sv/rfbdef_frame_core.sv
// Session phase tracking and message framing; produces one result per item at most.
`default_nettype none

module rfbdef_frame_core
    import rfbdef_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    input  wire logic [7:0]   item_byte,
    input  wire logic         item_restart,
    output logic              res_valid,
    output result_t           res
);

    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic [2:0]        msg_type_reg, msg_type_next;
    logic [IDX_W-1:0]  msg_total_reg, msg_total_next;
    logic [31:0]       cap_word_reg, cap_word_next;
    logic [15:0]       cap_half_reg, cap_half_next;
    logic [7:0]        cap_flag_reg, cap_flag_next;

    logic              more_bytes;

    always_comb
    begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        msg_type_next   = msg_type_reg;
        msg_total_next  = msg_total_reg;
        cap_word_next   = cap_word_reg;
        cap_half_next   = cap_half_reg;
        cap_flag_next   = cap_flag_reg;
        res_valid       = 1'b0;
        res             = '0;
        more_bytes      = 1'b0;

        if (item_valid)
        begin
            if (item_restart)
            begin
                phase_next      = PH_VERSION;
                byte_index_next = '0;
                msg_type_next   = '0;
                msg_total_next  = '0;
                cap_word_next   = '0;
                cap_half_next   = '0;
                cap_flag_next   = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_VERSION:
                    begin
                        if (byte_index_reg >= VERSION_LAST)
                        begin
                            byte_index_next = '0;
                            phase_next      = PH_INIT;
                            res_valid       = 1'b1;
                            res.event_kind  = KIND_SEND_SECURITY;
                        end
                        else
                        begin
                            byte_index_next = byte_index_reg + 1'b1;
                        end
                    end
                    PH_INIT:
                    begin
                        byte_index_next = '0;
                        phase_next      = PH_READY;
                        res_valid       = 1'b1;
                        res.event_kind  = KIND_SEND_INIT;
                    end
                    PH_READY:
                    begin
                        if (byte_index_reg == POS_TYPE)
                        begin
                            msg_type_next = item_byte[2:0];
                            cap_word_next = '0;
                            cap_half_next = '0;
                            cap_flag_next = '0;
                            case (item_byte)
                                MSG_SET_PIXEL_FORMAT: msg_total_next = LEN_PIXEL_FORMAT;
                                MSG_SET_ENCODINGS:    msg_total_next = LEN_ENC_HEADER;
                                MSG_UPDATE_REQ:       msg_total_next = LEN_UPDATE_REQ;
                                MSG_KEY_EVENT:        msg_total_next = LEN_KEY_EVENT;
                                MSG_POINTER_EVENT:    msg_total_next = LEN_POINTER_EVENT;
                                MSG_CUT_TEXT:         msg_total_next = LEN_CUT_HEADER;
                                default:
                                begin
                                    // unknown type: close the stream, keep framing state
                                    msg_type_next  = msg_type_reg;
                                    cap_word_next  = cap_word_reg;
                                    cap_half_next  = cap_half_reg;
                                    cap_flag_next  = cap_flag_reg;
                                    phase_next     = PH_CLOSED;
                                    res_valid      = 1'b1;
                                    res.event_kind = KIND_ERROR_CLOSE;
                                end
                            endcase
                        end
                        else if (byte_index_reg == POS_FLAG)
                        begin
                            cap_flag_next = item_byte;
                        end
                        else if (byte_index_reg <= POS_HALF_LAST)
                        begin
                            cap_half_next = {cap_half_reg[7:0], item_byte};
                            if (byte_index_reg == POS_HALF_LAST &&
                                msg_type_reg == TYPE_SET_ENCODINGS)
                            begin
                                msg_total_next = LEN_ENC_HEADER +
                                                 {15'd0, cap_half_next, 2'b00};
                            end
                        end
                        else if (byte_index_reg <= POS_WORD_LAST)
                        begin
                            cap_word_next = {cap_word_reg[23:0], item_byte};
                            if (byte_index_reg == POS_WORD_LAST &&
                                msg_type_reg == TYPE_CUT_TEXT)
                            begin
                                msg_total_next = LEN_CUT_HEADER + {1'b0, cap_word_next};
                            end
                        end

                        if (phase_next == PH_READY)
                        begin
                            more_bytes = ({1'b0, byte_index_reg} + 34'd1) <
                                         {1'b0, msg_total_next};
                            if (more_bytes)
                            begin
                                byte_index_next = byte_index_reg + 1'b1;
                            end
                            else
                            begin
                                // last byte of the message: report it
                                byte_index_next = '0;
                                res_valid       = 1'b1;
                                case (msg_type_next)
                                    TYPE_UPDATE_REQ:
                                    begin
                                        res.event_kind = KIND_UPDATE_REQ;
                                    end
                                    TYPE_KEY_EVENT:
                                    begin
                                        res.event_kind  = KIND_KEY;
                                        res.key_pressed = (cap_flag_next != 8'd0);
                                        res.keysym      = cap_word_next;
                                    end
                                    TYPE_POINTER_EVENT:
                                    begin
                                        res.event_kind  = KIND_POINTER;
                                        res.pointer_x   = cap_half_next;
                                        res.pointer_y   = cap_word_next[15:0];
                                        res.button_mask = cap_flag_next;
                                    end
                                    default:
                                    begin
                                        res.event_kind = KIND_IGNORED;
                                    end
                                endcase
                            end
                        end
                    end
                    PH_CLOSED:
                    begin
                        // drop every byte until restart
                    end
                    default:
                    begin
                        phase_next = PH_CLOSED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_VERSION;
            byte_index_reg <= '0;
            msg_type_reg   <= '0;
            msg_total_reg  <= '0;
            cap_word_reg   <= '0;
            cap_half_reg   <= '0;
            cap_flag_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            msg_type_reg   <= msg_type_next;
            msg_total_reg  <= msg_total_next;
            cap_word_reg   <= cap_word_next;
            cap_half_reg   <= cap_half_next;
            cap_flag_reg   <= cap_flag_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rfbdef_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module rfbdef_out_buf
    import rfbdef_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire result_t  push_data,
    output logic          full,
    output logic          out_valid,
    input  wire logic     out_stall,
    output result_t       out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            // no push can arrive while the skid slot is occupied
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (main_valid_reg)
        begin
            if (push && pop)
            begin
                main_next = push_data;
            end
            else if (push)
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
            else if (pop)
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            main_next       = push_data;
            main_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire
